FILE: hdl/ean8_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ean8_pkg - shared types and constants for the EAN-8 encoder
// Status codes, symbol geometry, guard patterns and the L-set code table.
// ----------------------------------------------------------------------------
package ean8_pkg;

  // Result status carried on every output beat
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_CHECK = 2'd1,
    ST_DIGIT = 2'd2
  } ean8_status_e;

  // Symbol geometry
  localparam int unsigned CORE_W   = 67;             // guards plus eight digits
  localparam int unsigned QZ_W     = 5;
  localparam logic [QZ_W-1:0] QZ_MAX = 5'd21;        // largest usable quiet zone
  localparam int unsigned STREAM_W = CORE_W + 2 * 21; // longest run of modules
  localparam int unsigned PAD_W    = STREAM_W - CORE_W;
  localparam int unsigned LEN_W    = 7;              // holds STREAM_W
  localparam int unsigned CHUNK_W  = 7;
  localparam int unsigned CNT_W    = 3;

  localparam logic [2:0] START_GUARD = 3'b101;
  localparam logic [4:0] MID_GUARD   = 5'b01010;
  localparam logic [2:0] END_GUARD   = 3'b101;

  // One queued item: outcome, symbol core and the quiet zone to wrap it in
  typedef struct packed {
    ean8_status_e          status;
    logic [CORE_W-1:0]     core;
    logic [QZ_W-1:0]       qz;
  } ean8_entry_t;

  // Left-hand (set A) code of one digit; digits above nine give all zeros
  function automatic logic [6:0] l_code(input logic [3:0] d);
    logic [6:0] c;
    unique case (d)
      4'd0:    c = 7'b0001101;
      4'd1:    c = 7'b0011001;
      4'd2:    c = 7'b0010011;
      4'd3:    c = 7'b0111101;
      4'd4:    c = 7'b0100011;
      4'd5:    c = 7'b0110001;
      4'd6:    c = 7'b0101111;
      4'd7:    c = 7'b0111011;
      4'd8:    c = 7'b0110111;
      4'd9:    c = 7'b0001011;
      default: c = 7'b0000000;
    endcase
    return c;
  endfunction

  // Right-hand code is the bitwise complement of the left-hand one
  function automatic logic [6:0] r_code(input logic [3:0] d);
    return ~l_code(d);
  endfunction

endpackage

FILE: hdl/ean8_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ean8_if - stream interfaces of the EAN-8 encoder
// Digit input channel and module-chunk output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ean8_digits_if;
  logic        valid;
  logic        ready;
  logic [31:0] digits;

  modport source (output valid, output digits, input ready);
  modport sink   (input valid, input digits, output ready);
endinterface

interface ean8_chunk_if;
  logic       valid;
  logic       ready;
  logic [6:0] modules;
  logic [2:0] module_count;
  logic [1:0] status;
  logic       last;

  modport source (output valid, output modules, output module_count,
                  output status, output last, input ready);
  modport sink   (input valid, input modules, input module_count,
                  input status, input last, output ready);
endinterface

FILE: hdl/ean8_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ean8_front - digit intake and classification
// Checks the digits and the check digit, assembles the symbol core and
// pushes one entry per accepted beat into the queue.
// ----------------------------------------------------------------------------
module ean8_front (
  ean8_digits_if.sink          digits_i,
  input  logic [4:0]           qz_i,
  input  logic                 full_i,
  output logic                 push_o,
  output ean8_pkg::ean8_entry_t entry_o
);

  logic [3:0] d [8];
  logic       bad_digit;
  logic [5:0] sum3;
  logic [4:0] sum1;
  logic [7:0] sum;
  logic [15:0] prod;
  logic [3:0] quot;
  logic [7:0] rem_w;
  logic [3:0] rem;
  logic [3:0] expect_d;

  // Accept whenever the queue has room
  assign digits_i.ready = !full_i;
  assign push_o         = digits_i.valid && !full_i;

  // Split into nibbles and flag any digit above nine
  always_comb begin
    bad_digit = 1'b0;
    for (int i = 0; i < 8; i++) begin
      d[i] = digits_i.digits[4*i +: 4];
      if (d[i] > 4'd9) bad_digit = 1'b1;
    end
  end

  // Weighted sum: even positions x3, odd x1, first seven digits
  assign sum3 = 6'(d[0]) + 6'(d[2]) + 6'(d[4]) + 6'(d[6]);
  assign sum1 = 5'(d[1]) + 5'(d[3]) + 5'(d[5]);
  assign sum  = 8'({sum3, 1'b0}) + 8'(sum3) + 8'(sum1);

  // sum mod 10 by reciprocal multiply (exact for sums below 160, which
  // covers every all-BCD word)
  assign prod     = 16'(sum) * 16'd205;
  assign quot     = prod[14:11];
  assign rem_w    = sum - 8'({quot, 3'b000}) - 8'({quot, 1'b0});
  assign rem      = rem_w[3:0];
  assign expect_d = (rem == 4'd0) ? 4'd0 : 4'd10 - rem;

  // Classify and build the queue entry
  always_comb begin
    if (bad_digit) begin
      entry_o.status = ean8_pkg::ST_DIGIT;
    end else if (expect_d != d[7]) begin
      entry_o.status = ean8_pkg::ST_CHECK;
    end else begin
      entry_o.status = ean8_pkg::ST_OK;
    end
    entry_o.core = {ean8_pkg::START_GUARD,
                    ean8_pkg::l_code(d[0]), ean8_pkg::l_code(d[1]),
                    ean8_pkg::l_code(d[2]), ean8_pkg::l_code(d[3]),
                    ean8_pkg::MID_GUARD,
                    ean8_pkg::r_code(d[4]), ean8_pkg::r_code(d[5]),
                    ean8_pkg::r_code(d[6]), ean8_pkg::r_code(d[7]),
                    ean8_pkg::END_GUARD};
    entry_o.qz = (qz_i > ean8_pkg::QZ_MAX) ? ean8_pkg::QZ_MAX : qz_i;
  end

endmodule

FILE: hdl/ean8_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ean8_fifo - short entry queue between front and back
// Circular buffer of classified items; first-word fall-through read.
// ----------------------------------------------------------------------------
module ean8_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  ean8_pkg::ean8_entry_t entry_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output logic                  valid_o,
  output ean8_pkg::ean8_entry_t entry_o
);

  localparam int unsigned IdxW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  ean8_pkg::ean8_entry_t store_q [Depth];
  logic [IdxW-1:0] wr_ptr_q, wr_ptr_d;
  logic [IdxW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] fill_q, fill_d;
  logic            do_push, do_pop;

  assign full_o  = (fill_q == FullCnt);
  assign valid_o = (fill_q != '0);
  assign entry_o = store_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointer and fill update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (do_push) wr_ptr_d = (wr_ptr_q == LastIdx) ? '0 : wr_ptr_q + 1'b1;
    if (do_pop)  rd_ptr_d = (rd_ptr_q == LastIdx) ? '0 : rd_ptr_q + 1'b1;
    if (do_push && !do_pop) fill_d = fill_q + 1'b1;
    if (do_pop && !do_push) fill_d = fill_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) store_q[wr_ptr_q] <= entry_i;
  end

endmodule

FILE: hdl/ean8_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ean8_back - module stream emitter
// Loads one queue entry into a shift register and sends it as seven-module
// chunks, or sends a single error beat.
// ----------------------------------------------------------------------------
module ean8_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  input  ean8_pkg::ean8_entry_t q_entry_i,
  output logic                  pop_o,
  ean8_chunk_if.source          chunk_o
);

  localparam int unsigned SW = ean8_pkg::STREAM_W;
  localparam int unsigned LW = ean8_pkg::LEN_W;

  logic                    busy_q, busy_d;
  logic [SW-1:0]           sr_q, sr_d;
  logic [LW-1:0]           rem_q, rem_d;
  ean8_pkg::ean8_status_e  status_q, status_d;
  logic                    is_err, is_last, fire, load;
  logic [2:0]              count;
  logic [6:0]              top7;
  logic [SW-1:0]           stream;
  logic [LW-1:0]           len;

  // Current beat, straight from the registers
  assign is_err  = (status_q != ean8_pkg::ST_OK);
  assign is_last = is_err || (rem_q <= LW'(ean8_pkg::CHUNK_W));
  assign count   = is_err ? 3'd0 :
                   (rem_q >= LW'(ean8_pkg::CHUNK_W)) ? 3'd7 : rem_q[2:0];
  assign top7    = sr_q[SW-1 -: ean8_pkg::CHUNK_W];

  assign chunk_o.valid        = busy_q;
  assign chunk_o.modules      = is_err ? 7'd0 : (top7 >> (3'd7 - count));
  assign chunk_o.module_count = count;
  assign chunk_o.status       = status_q;
  assign chunk_o.last         = is_last;

  assign fire  = busy_q && chunk_o.ready;
  assign load  = q_valid_i && (!busy_q || (fire && is_last));
  assign pop_o = load;

  // Place the core behind the leading quiet zone; trailing zeros are implicit
  assign stream = {q_entry_i.core, {ean8_pkg::PAD_W{1'b0}}} >> q_entry_i.qz;
  assign len    = LW'(ean8_pkg::CORE_W) + LW'({q_entry_i.qz, 1'b0});

  // Run control
  always_comb begin
    busy_d   = busy_q;
    sr_d     = sr_q;
    rem_d    = rem_q;
    status_d = status_q;
    if (load) begin
      busy_d   = 1'b1;
      sr_d     = stream;
      rem_d    = len;
      status_d = q_entry_i.status;
    end else if (fire) begin
      if (is_last) begin
        busy_d = 1'b0;
      end else begin
        sr_d  = sr_q << ean8_pkg::CHUNK_W;
        rem_d = rem_q - LW'(ean8_pkg::CHUNK_W);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      status_q <= ean8_pkg::ST_OK;
      rem_q    <= '0;
    end else begin
      busy_q   <= busy_d;
      status_q <= status_d;
      rem_q    <= rem_d;
    end
  end

  // Payload shift register
  always_ff @(posedge clk_i) begin
    sr_q <= sr_d;
  end

endmodule

FILE: hdl/ean8_barcode_encoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ean8_barcode_encoder_top - EAN-8 barcode encoder
// Validates eight BCD digits and streams the symbol's modules in chunks.
// ----------------------------------------------------------------------------
//  port          dir  kind          beat contents
//  digits_i      in   valid/ready   digits[31:0], digit 0 in low nibble
//  chunk_o       out  valid/ready   modules, module_count, status, last
//  cfg_we_i      in   write strobe  cfg_wdata_i = quiet zone width
//
//  A good item gives ceil((67 + 2*qz) / 7) beats (10 to 16), one per cycle
//  unless chunk_o.ready is low; a bad item gives one error beat. The chunk
//  shift register in the back end sets the rate. Intake goes on while the
//  queue has room, so the next item is taken while the current run drains.
//  Reset empties queue and emitter, sets quiet zone to 7; no clearing pass.
// ----------------------------------------------------------------------------
module ean8_barcode_encoder_top #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [4:0]    cfg_wdata_i,
  ean8_digits_if.sink   digits_i,
  ean8_chunk_if.source  chunk_o
);

  logic [4:0]            qz_q;
  logic                  push, full, pop, q_valid;
  ean8_pkg::ean8_entry_t push_entry, head_entry;

  // Quiet zone register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qz_q <= 5'd7;
    end else if (cfg_we_i) begin
      qz_q <= cfg_wdata_i;
    end
  end

  ean8_front u_front (
    .digits_i (digits_i),
    .qz_i     (qz_q),
    .full_i   (full),
    .push_o   (push),
    .entry_o  (push_entry)
  );

  ean8_fifo #(.Depth(QueueDepth)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .entry_o (head_entry)
  );

  ean8_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_entry_i (head_entry),
    .pop_o     (pop),
    .chunk_o   (chunk_o)
  );

  // Error beats are single, empty and final
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    chunk_o.valid && (chunk_o.status != ean8_pkg::ST_OK)
      |-> (chunk_o.module_count == 3'd0) && chunk_o.last)
    else $error("error beat not empty or not last");

  // Every chunk of a good run but the final one is full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    chunk_o.valid && (chunk_o.status == ean8_pkg::ST_OK) && !chunk_o.last
      |-> (chunk_o.module_count == 3'd7))
    else $error("short chunk before end of run");

  // A run does not break off before its last beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    chunk_o.valid && chunk_o.ready && !chunk_o.last |=> chunk_o.valid)
    else $error("run stopped before last beat");

  // Nothing is queued while the queue reports full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> !digits_i.ready)
    else $error("intake open while queue full");

endmodule
